// File: rtl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define PT_ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// antecedent in a cycle implies consequent in the same cycle
`define PT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/pt_pkg.sv
package pt_pkg;

  // fixed field widths
  localparam int unsigned NODE_W     = 10;
  localparam int unsigned RAD_W      = 9;
  localparam int unsigned SAT_W      = 11;
  localparam int unsigned DIMS_W     = 3;
  localparam int unsigned CFG_W      = 6;
  localparam int unsigned CFG_ADDR_W = 3;

  // quotient bits resolved per division stage
  localparam int unsigned DIV_SPLIT = NODE_W / 2;

  // saturation value: first count that no longer fits a node index
  localparam logic [SAT_W-1:0] SAT_LIMIT = 11'd1024;

  typedef enum logic [2:0] {
    MODE_BITCOMP   = 3'd0,
    MODE_TRANSPOSE = 3'd1,
    MODE_BITREV    = 3'd2,
    MODE_SHUFFLE   = 3'd3,
    MODE_TORNADO   = 3'd4,
    MODE_NEIGHBOR  = 3'd5
  } pt_mode_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PATTERN_MODE = 3'd0,
    REG_NODE_BITS    = 3'd1,
    REG_PER_DIM_RAD  = 3'd2,
    REG_DIMS         = 3'd3,
    REG_RADIX_MULT   = 3'd4
  } pt_reg_e;

  // digit-mode settings seen by every cell
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [RAD_W-1:0]  add;
    logic [DIMS_W-1:0] dims;
  } pt_cfg_t;

  // word travelling down the cell chain
  typedef struct packed {
    logic              valid;
    logic              digit;
    logic              bad;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] q;
    logic [RAD_W-1:0]  r;
    logic [SAT_W-1:0]  off;
    logic [SAT_W-1:0]  res;
    logic [NODE_W-1:0] dest;
  } pt_item_t;

endpackage

// File: rtl/pt_div_stage.sv
module pt_div_stage #(
  parameter int unsigned STEPS     = 5,
  parameter bit          CLEAR_REM = 1'b0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pt_pkg::pt_cfg_t  cfg_i,
  input  pt_pkg::pt_item_t item_i,
  output pt_pkg::pt_item_t item_o
);
  import pt_pkg::*;

  pt_item_t item_d, item_q;

  // restoring division steps on the {r, q} pair, one quotient bit each
  always_comb begin
    logic [RAD_W:0]    t;
    logic [NODE_W-1:0] q;
    logic [RAD_W-1:0]  r;
    item_d = item_i;
    q = item_i.q;
    r = CLEAR_REM ? '0 : item_i.r;
    t = '0;
    for (int k = 0; k < STEPS; k++) begin
      t = {r, q[NODE_W-1]};
      q = {q[NODE_W-2:0], 1'b0};
      if (t >= {1'b0, cfg_i.rad}) begin
        r    = RAD_W'(t - {1'b0, cfg_i.rad});
        q[0] = 1'b1;
      end else begin
        r = t[RAD_W-1:0];
      end
    end
    item_d.q = q;
    item_d.r = r;
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// File: rtl/pt_digit_cell.sv
module pt_digit_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pt_pkg::pt_cfg_t  cfg_i,
  input  pt_pkg::pt_item_t item_i,
  output pt_pkg::pt_item_t item_o
);
  import pt_pkg::*;

  localparam int unsigned PROD_W = SAT_W + RAD_W;
  localparam logic [DIMS_W-1:0] IDX_L = DIMS_W'(IDX);

  pt_item_t a_item, b_item;
  pt_item_t acc_d, acc_q;

  // upper quotient bits, remainder starts from zero for this digit
  pt_div_stage #(
    .STEPS     (DIV_SPLIT),
    .CLEAR_REM (1'b1)
  ) u_div_hi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .item_i (item_i),
    .item_o (a_item)
  );

  // lower quotient bits, remainder is the digit afterwards
  pt_div_stage #(
    .STEPS     (NODE_W - DIV_SPLIT),
    .CLEAR_REM (1'b0)
  ) u_div_lo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .item_i (a_item),
    .item_o (b_item)
  );

  // shift the digit, weight it and fold it into the destination
  always_comb begin
    logic [RAD_W:0]    sum;
    logic [RAD_W-1:0]  nd;
    logic [PROD_W-1:0] p_res;
    logic [PROD_W-1:0] p_off;
    logic [PROD_W:0]   res_sum;
    logic              active;
    acc_d   = b_item;
    active  = b_item.digit && (cfg_i.dims > IDX_L);
    sum     = {1'b0, b_item.r} + {1'b0, cfg_i.add};
    nd      = (sum >= {1'b0, cfg_i.rad}) ? RAD_W'(sum - {1'b0, cfg_i.rad}) : sum[RAD_W-1:0];
    p_res   = PROD_W'(b_item.off) * PROD_W'(nd);
    p_off   = PROD_W'(b_item.off) * PROD_W'(cfg_i.rad);
    res_sum = {1'b0, p_res} + (PROD_W+1)'(b_item.res);
    if (active) begin
      acc_d.res = (res_sum >= (PROD_W+1)'(SAT_LIMIT)) ? SAT_LIMIT : res_sum[SAT_W-1:0];
      acc_d.off = (p_off >= PROD_W'(SAT_LIMIT)) ? SAT_LIMIT : p_off[SAT_W-1:0];
    end
  end

  // accumulate stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign item_o = acc_q;

endmodule

// File: rtl/permutation_traffic_destination.sv
// Destination of one source node under a synthetic permutation pattern.
// One word is taken per clock with no gaps: start_i is accepted whenever
// it is high, and busy_o stays low. Each result shows on done_o for one
// cycle, in order; the receiver must take it then. Each result passes
// through the input register, the chain of MAX_DIMS digit cells, three
// register stages each (two halves of the division by the radix and one
// accumulate stage), and the output register. Configuration writes take
// effect at once and belong to times when no word is in flight.
module permutation_traffic_destination #(
  parameter int unsigned MAX_NODE_BITS = 10,
  parameter int unsigned MAX_DIMS      = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pt_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [pt_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                            start_i,
  input  logic [pt_pkg::NODE_W-1:0]       source_node_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [pt_pkg::NODE_W-1:0]       dest_node_o,
  output logic                            bad_request_o
);
  import pt_pkg::*;

  localparam int unsigned CW = (MAX_NODE_BITS > NODE_W) ? MAX_NODE_BITS : NODE_W;

  logic [2:0]        mode_q;
  logic [3:0]        nb_q;
  logic [5:0]        pdr_q;
  logic [DIMS_W-1:0] dims_q;
  logic [2:0]        mult_q;

  pt_cfg_t           cfg;
  logic [RAD_W-1:0]  rad;
  logic [RAD_W:0]    rad_p1;

  pt_item_t          item0_d, item0_q;
  pt_item_t          chain [MAX_DIMS+1];

  logic              done_q, done_d;
  logic              bad_q, bad_d;
  logic [NODE_W-1:0] dest_q, dest_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BITCOMP;
      nb_q   <= 4'd6;
      pdr_q  <= 6'd4;
      dims_q <= 3'd2;
      mult_q <= 3'd1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_PATTERN_MODE: mode_q <= cfg_wdata_i[2:0];
        REG_NODE_BITS:    nb_q   <= cfg_wdata_i[3:0];
        REG_PER_DIM_RAD:  pdr_q  <= cfg_wdata_i[5:0];
        REG_DIMS:         dims_q <= cfg_wdata_i[DIMS_W-1:0];
        REG_RADIX_MULT:   mult_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // digit radix and per-digit offset
  assign rad    = RAD_W'(mult_q) * RAD_W'(pdr_q);
  assign rad_p1 = {1'b0, rad} + (RAD_W+1)'(1);
  assign cfg.rad  = rad;
  assign cfg.add  = (mode_q == MODE_TORNADO) ? RAD_W'(rad_p1[RAD_W:1] - RAD_W'(1))
                                             : RAD_W'(1);
  assign cfg.dims = dims_q;

  // bit permutations and the checks known at entry
  always_comb begin
    logic [CW-1:0] s_ext;
    logic [CW-1:0] mask;
    logic [CW-1:0] lo;
    logic [CW-1:0] rev;
    logic [CW-1:0] s_top;
    logic [CW-1:0] r_bits;
    logic [CW:0]   one_sh;
    logic [CW:0]   lo_sh;
    logic [2:0]    h;
    logic [4:0]    rsh;
    logic [3:0]    nb_m1;
    logic          bit_bad;
    logic          digit_bad;
    logic          is_bit;
    logic          is_digit;
    s_ext   = CW'(source_node_i);
    one_sh  = (CW+1)'(1) << nb_q;
    mask    = CW'(one_sh - (CW+1)'(1));
    bit_bad = ({1'b0, nb_q} > 5'(MAX_NODE_BITS)) || (s_ext > mask);
    h       = nb_q[3:1];
    lo_sh   = (CW+1)'(1) << h;
    lo      = CW'(lo_sh - (CW+1)'(1));
    for (int j = 0; j < CW; j++) begin
      rev[j] = s_ext[CW-1-j];
    end
    rsh     = 5'(CW) - {1'b0, nb_q};
    nb_m1   = nb_q - 4'd1;
    s_top   = s_ext >> nb_m1;
    case (mode_q)
      MODE_BITCOMP: begin
        r_bits = ~s_ext & mask;
      end
      MODE_TRANSPOSE: begin
        r_bits  = ((s_ext >> h) & lo) | ((s_ext << h) & (lo << h));
        bit_bad = bit_bad || nb_q[0];
      end
      MODE_BITREV: begin
        r_bits = rev >> rsh;
      end
      MODE_SHUFFLE: begin
        r_bits = (nb_q == 4'd0) ? '0 : (((s_ext << 1) & mask) | CW'(s_top[0]));
      end
      default: begin
        r_bits = '0;
      end
    endcase
    is_bit    = mode_q inside {MODE_BITCOMP, MODE_TRANSPOSE, MODE_BITREV, MODE_SHUFFLE};
    is_digit  = mode_q inside {MODE_TORNADO, MODE_NEIGHBOR};
    digit_bad = (rad == '0) || ({1'b0, dims_q} > (DIMS_W+1)'(MAX_DIMS));

    item0_d.valid = start_i && !busy_o;
    item0_d.digit = is_digit;
    item0_d.bad   = is_bit ? bit_bad : (is_digit ? digit_bad : 1'b1);
    item0_d.src   = source_node_i;
    item0_d.q     = source_node_i;
    item0_d.r     = '0;
    item0_d.off   = SAT_W'(1);
    item0_d.res   = '0;
    item0_d.dest  = r_bits[NODE_W-1:0];
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item0_q <= '0;
    end else begin
      item0_q <= item0_d;
    end
  end

  assign chain[0] = item0_q;

  // one cell per digit, least significant first
  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_cell
    pt_digit_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (cfg),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  // node count and range checks on the finished digit word
  always_comb begin
    pt_item_t last;
    logic     dig_bad;
    last    = chain[MAX_DIMS];
    dig_bad = last.digit && ((SAT_W'(last.src) >= last.off) || (last.res >= SAT_LIMIT));
    done_d  = last.valid;
    bad_d   = last.bad || dig_bad;
    if (bad_d) begin
      dest_d = '0;
    end else if (last.digit) begin
      dest_d = last.res[NODE_W-1:0];
    end else begin
      dest_d = last.dest;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      bad_q  <= 1'b0;
      dest_q <= '0;
    end else begin
      done_q <= done_d;
      bad_q  <= bad_d;
      dest_q <= dest_d;
    end
  end

  assign busy_o        = 1'b0;
  assign done_o        = done_q;
  assign bad_request_o = bad_q;
  assign dest_node_o   = dest_q;

endmodule

// File: rtl/pt_checker.sv
`include "assert_macros.svh"

module pt_checker #(
  parameter int unsigned MAX_DIMS = 4
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      done_o,
  input logic [pt_pkg::NODE_W-1:0] dest_node_o,
  input logic                      bad_request_o
);

  localparam int unsigned LAT = 3 * MAX_DIMS + 2;

  // a result word only appears a fixed latency after an accepted start
  `PT_ASSERT_IMPL(a_done_latency, clk_i, rst_ni, done_o, $past(start_i && !busy_o, LAT))

  // a refused request carries a zero destination
  `PT_ASSERT_IMPL(a_bad_zero, clk_i, rst_ni, done_o && bad_request_o, dest_node_o == '0)

  // the block takes a word every cycle
  `PT_ASSERT_ALWAYS(a_never_busy, clk_i, rst_ni, !busy_o)

endmodule

bind permutation_traffic_destination pt_checker #(
  .MAX_DIMS (MAX_DIMS)
) u_pt_checker (.*);

// File: sim/tb_permutation_traffic_destination.sv
module tb_permutation_traffic_destination;
  timeunit 1ns;
  timeprecision 1ps;

  import pt_pkg::*;

  localparam int unsigned MAX_NODE_BITS = 10;
  localparam int unsigned MAX_DIMS      = 4;
  localparam int unsigned LATENCY       = 3 * MAX_DIMS + 2;
  localparam longint unsigned DEST_MAX  = 1023;

  // mode codes that the block leaves unused
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  typedef struct {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dest;
    logic              bad;
  } dest_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_W-1:0]      cfg_wdata_i;
  logic                  start_i;
  logic [NODE_W-1:0]     source_node_i;
  logic                  busy_o;
  logic                  done_o;
  logic [NODE_W-1:0]     dest_node_o;
  logic                  bad_request_o;

  // local copy of the configuration registers
  logic [2:0] mode_cfg;
  logic [3:0] node_bits_cfg;
  logic [5:0] radix_cfg;
  logic [2:0] dims_cfg;
  logic [2:0] mult_cfg;

  dest_word_t pending_dest_q[$];
  int         err_count;

  permutation_traffic_destination #(
    .MAX_NODE_BITS(MAX_NODE_BITS),
    .MAX_DIMS     (MAX_DIMS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start_i),
    .source_node_i(source_node_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .dest_node_o  (dest_node_o),
    .bad_request_o(bad_request_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard limit on run time
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // destination of one source under the current settings
  function automatic void permute_node(input logic [NODE_W-1:0] src,
                                       output logic [NODE_W-1:0] dest,
                                       output logic bad);
    longint unsigned s, nb, mask, h, lo, r;
    longint unsigned rad, count, off, res, add, dig, nd;
    bit ok, big;
    s    = 64'(src);
    r    = 0;
    res  = 0;
    ok   = 1'b1;
    big  = 1'b0;
    nb   = 64'(node_bits_cfg);
    case (mode_cfg)
      MODE_BITCOMP, MODE_TRANSPOSE, MODE_BITREV, MODE_SHUFFLE: begin
        mask = (64'd1 << nb) - 1;
        if (nb > MAX_NODE_BITS || s > mask) begin
          ok = 1'b0;
        end else if (mode_cfg == MODE_BITCOMP) begin
          r = ~s & mask;
        end else if (mode_cfg == MODE_TRANSPOSE) begin
          if (nb[0]) begin
            ok = 1'b0;
          end else begin
            h  = nb >> 1;
            lo = (64'd1 << h) - 1;
            r  = ((s >> h) & lo) | ((s << h) & (lo << h));
          end
        end else if (mode_cfg == MODE_BITREV) begin
          for (int i = 0; i < nb; i++) r = (r << 1) | ((s >> i) & 1);
        end else begin
          r = (nb == 0) ? 0 : (((s << 1) & mask) | ((s >> (nb - 1)) & 1));
        end
      end
      MODE_TORNADO, MODE_NEIGHBOR: begin
        rad   = 64'(mult_cfg) * 64'(radix_cfg);
        count = 1;
        off   = 1;
        if (rad == 0 || dims_cfg > MAX_DIMS) begin
          ok = 1'b0;
        end else begin
          for (int i = 0; i < dims_cfg; i++) begin
            count = count * rad;
            if (count > DEST_MAX) count = DEST_MAX + 1;
          end
          if (s >= count) ok = 1'b0;
          add = (mode_cfg == MODE_TORNADO) ? ((rad + 1) / 2 - 1) : 1;
          // walk the digits, least significant first
          for (int i = 0; i < dims_cfg && ok; i++) begin
            dig = big ? 0 : (s / off) % rad;
            nd  = (dig + add) % rad;
            if (nd != 0) begin
              if (big) ok = 1'b0;
              else res = res + off * nd;
            end
            if (!big) begin
              off = off * rad;
              if (off > DEST_MAX) big = 1'b1;
            end
          end
          if (res > DEST_MAX) ok = 1'b0;
          r = res;
        end
      end
      default: ok = 1'b0;
    endcase
    dest = ok ? r[NODE_W-1:0] : '0;
    bad  = !ok;
  endfunction

  // number of valid sources under the current settings, 0 if none
  function automatic int node_span();
    int rad, count;
    case (mode_cfg)
      MODE_BITCOMP, MODE_TRANSPOSE, MODE_BITREV, MODE_SHUFFLE:
        return (node_bits_cfg > MAX_NODE_BITS) ? 0 : (1 << node_bits_cfg);
      MODE_TORNADO, MODE_NEIGHBOR: begin
        rad   = int'(mult_cfg) * int'(radix_cfg);
        count = 1;
        if (rad == 0 || dims_cfg > MAX_DIMS) return 0;
        for (int i = 0; i < dims_cfg; i++) begin
          count = count * rad;
          if (count > 1024) count = 1024;
        end
        return count;
      end
      default: return 0;
    endcase
  endfunction

  // mostly in-range sources, some anywhere in the field
  function automatic logic [NODE_W-1:0] pick_source();
    int span;
    span = node_span();
    if (span > 0 && $urandom_range(0, 99) < 85) return NODE_W'($urandom_range(0, span - 1));
    return NODE_W'($urandom_range(0, 1023));
  endfunction

  // append one expected word behind the ones already waiting
  function automatic void enqueue_dest(input dest_word_t w);
    pending_dest_q = {pending_dest_q, w};
  endfunction

  // check each result word against the oldest expectation
  always @(posedge clk_i) begin
    dest_word_t exp_w;
    if (rst_ni && done_o) begin
      if (pending_dest_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected word: dest=%0d bad=%0b", dest_node_o, bad_request_o);
      end else begin
        exp_w = pending_dest_q.pop_front();
        if (dest_node_o !== exp_w.dest || bad_request_o !== exp_w.bad) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch src=%0d: expected dest=%0d bad=%0b, got dest=%0d bad=%0b",
                     exp_w.src, exp_w.dest, exp_w.bad, dest_node_o, bad_request_o);
        end
      end
    end
  end

  // offer one word and hold it until it is taken
  task automatic send_word(input logic [NODE_W-1:0] src);
    logic [NODE_W-1:0] d;
    logic              b;
    dest_word_t        w;
    @(negedge clk_i);
    start_i       <= 1'b1;
    source_node_i <= src;
    do @(posedge clk_i); while (busy_o);
    permute_node(src, d, b);
    w = '{src: src, dest: d, bad: b};
    enqueue_dest(w);
  endtask

  // sender gap set by n, with noise on the source port
  task automatic pause_sender(input int n);
    @(negedge clk_i);
    start_i       <= 1'b0;
    source_node_i <= NODE_W'($urandom);
    repeat (n - 1) @(negedge clk_i);
  endtask

  // stop sending and let every word in flight come out
  task automatic wait_drained();
    pause_sender(1);
    while (pending_dest_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input pt_reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_PATTERN_MODE: mode_cfg      = val[2:0];
      REG_NODE_BITS:    node_bits_cfg = val[3:0];
      REG_PER_DIM_RAD:  radix_cfg     = val[5:0];
      REG_DIMS:         dims_cfg      = val[2:0];
      REG_RADIX_MULT:   mult_cfg      = val[2:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= CFG_W'($urandom);
  endtask

  // full register set, written once the block is idle
  task automatic apply_cfg(input logic [2:0] mode, input int nb, input int rad,
                           input int nd, input int mult);
    wait_drained();
    write_reg(REG_PATTERN_MODE, CFG_W'(mode));
    write_reg(REG_NODE_BITS, CFG_W'(nb));
    write_reg(REG_PER_DIM_RAD, CFG_W'(rad));
    write_reg(REG_DIMS, CFG_W'(nd));
    write_reg(REG_RADIX_MULT, CFG_W'(mult));
  endtask

  task automatic random_cfg();
    logic [2:0] mode;
    int nb, rad, nd, mult, pick;
    mode = ($urandom_range(0, 99) < 92) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
    nb   = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 10) : $urandom_range(11, 15);
    pick = $urandom_range(0, 99);
    if (pick < 50)      rad = $urandom_range(1, 8);
    else if (pick < 85) rad = $urandom_range(1, 32);
    else                rad = $urandom_range(0, 63);
    nd   = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4) : $urandom_range(0, 7);
    mult = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4) : $urandom_range(0, 7);
    apply_cfg(mode, nb, rad, nd, mult);
  endtask

  // settings straight out of reset
  task automatic test_reset_config();
    mode_cfg      = MODE_BITCOMP;
    node_bits_cfg = 4'd6;
    radix_cfg     = 6'd4;
    dims_cfg      = 3'd2;
    mult_cfg      = 3'd1;
    send_word(10'd0);
    send_word(10'd63);
    send_word(10'd64);
    send_word(10'd1023);
  endtask

  task automatic test_bit_modes();
    apply_cfg(MODE_BITCOMP, 10, 4, 2, 1);
    send_word(10'd0);
    send_word(10'd1023);
    apply_cfg(MODE_TRANSPOSE, 10, 4, 2, 1);
    send_word(10'h01F);
    send_word(10'h2A5);
    // transpose needs an even bit count
    apply_cfg(MODE_TRANSPOSE, 9, 4, 2, 1);
    send_word(10'h005);
    apply_cfg(MODE_BITREV, 10, 4, 2, 1);
    send_word(10'h001);
    send_word(10'h155);
    apply_cfg(MODE_SHUFFLE, 10, 4, 2, 1);
    send_word(10'h200);
    // single node
    apply_cfg(MODE_SHUFFLE, 0, 4, 2, 1);
    send_word(10'd0);
    // bit counts above the maximum
    apply_cfg(MODE_BITREV, 11, 4, 2, 1);
    send_word(10'd0);
    apply_cfg(MODE_BITCOMP, 15, 4, 2, 1);
    send_word(10'd5);
  endtask

  task automatic test_digit_modes();
    apply_cfg(MODE_TORNADO, 6, 32, 1, 4);
    send_word(10'd127);
    send_word(10'd128);
    // destination does not fit the output
    apply_cfg(MODE_TORNADO, 6, 32, 2, 4);
    send_word(10'd1023);
    // zero digits: one node
    apply_cfg(MODE_NEIGHBOR, 6, 4, 0, 1);
    send_word(10'd0);
    send_word(10'd1);
    // zero radix from either factor
    apply_cfg(MODE_NEIGHBOR, 6, 0, 2, 1);
    send_word(10'd0);
    apply_cfg(MODE_NEIGHBOR, 6, 4, 2, 0);
    send_word(10'd0);
    // too many digits
    apply_cfg(MODE_TORNADO, 6, 4, 5, 1);
    send_word(10'd0);
  endtask

  task automatic test_unused_modes();
    apply_cfg(MODE_SPARE_A, 6, 4, 2, 1);
    send_word(10'd0);
    apply_cfg(MODE_SPARE_B, 6, 4, 2, 1);
    send_word(10'd1);
  endtask

  // random words in bursts over a series of settings
  task automatic test_random_traffic();
    int burst;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: apply_cfg(MODE_SHUFFLE, 10, 32, 4, 4);
        1: apply_cfg(MODE_TORNADO, 0, 32, 1, 4);
        2: apply_cfg(MODE_NEIGHBOR, 15, 1, 4, 1);
        3: apply_cfg(MODE_TRANSPOSE, 10, 63, 7, 7);
        default: random_cfg();
      endcase
      burst = 0;
      for (int n = 0; n < 150; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 24);
          // every fourth phase runs back to back
          if (p % 4 != 1 && $urandom_range(0, 9) < 7) pause_sender($urandom_range(1, 8));
        end
        burst--;
        send_word(pick_source());
        if (p == 6 && n == 75) wait_drained();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    start_i       = 1'b0;
    source_node_i = '0;
    err_count     = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_config();
    test_bit_modes();
    test_digit_modes();
    test_unused_modes();
    test_random_traffic();

    wait_drained();
    if (err_count == 0 && pending_dest_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
